// ----- design/hpt_pkg.sv -----
// shared types, constants and helpers of the homogeneous point transform
package hpt_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned ENTRY_W = 16;
  localparam int unsigned ROW_W   = 4 * ENTRY_W;
  localparam int unsigned PROD_W  = COORD_W + ENTRY_W;
  localparam int unsigned ACC_W   = 50;
  localparam int unsigned MAG_W   = ACC_W;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned QB      = 31;
  localparam int unsigned RW      = MAG_W + QB;
  localparam int unsigned INT_LIM = 15;
  localparam int unsigned ROUND_SH = 12;

  localparam logic [1:0] OP_POINT  = 2'd0;
  localparam logic [1:0] OP_VECTOR = 2'd1;
  localparam logic [1:0] OP_AFFINE = 2'd2;

  localparam logic [1:0] REG_ROW0 = 2'd0;
  localparam logic [1:0] REG_ROW1 = 2'd1;
  localparam logic [1:0] REG_ROW2 = 2'd2;
  localparam logic [1:0] REG_ROW3 = 2'd3;

  localparam logic [ROW_W-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW2_RST = 64'h0000_1000_0000_0000;
  localparam logic [ROW_W-1:0] ROW3_RST = 64'h1000_0000_0000_0000;

  localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]                operation;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      divide_by_zero;
  } out_t;

  typedef struct packed {
    logic [1:0]               op;
    logic [2:0]               neg;
    logic [2:0]               ovf;
    logic                     wz;
    logic [2:0][COORD_W-1:0]  aff;
  } side_t;

  // round half up from q.28 to q16.16, then saturate
  function automatic logic signed [COORD_W-1:0] to_q16(logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0] t;
    logic signed [ACC_W:0] s;
    logic signed [ACC_W:0] smax;
    logic signed [ACC_W:0] smin;
    t    = (ACC_W+1)'(acc) + (ACC_W+1)'(1 << (ROUND_SH - 1));
    s    = t >>> ROUND_SH;
    smax = (ACC_W+1)'(Q_MAX);
    smin = (ACC_W+1)'(Q_MIN);
    if (s > smax) begin
      to_q16 = Q_MAX;
    end else if (s < smin) begin
      to_q16 = Q_MIN;
    end else begin
      to_q16 = s[COORD_W-1:0];
    end
  endfunction

endpackage

// ----- design/hpt_mac.sv -----
// matrix row products and row sums, two register stages
module hpt_mac (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  hpt_pkg::in_t                    data_i,
  input  logic [hpt_pkg::ROW_W-1:0]       row_i [4],
  output logic [1:0]                      op_o,
  output logic signed [hpt_pkg::ACC_W-1:0] acc_o [4]
);

  logic signed [hpt_pkg::PROD_W-1:0] prod_d [4][4];
  logic signed [hpt_pkg::PROD_W-1:0] prod_q [4][4];
  logic signed [hpt_pkg::ACC_W-1:0]  acc_d  [4];
  logic signed [hpt_pkg::ACC_W-1:0]  acc_q  [4];
  logic [1:0]                        op1_q;
  logic [1:0]                        op2_q;
  logic signed [hpt_pkg::COORD_W-1:0] coord [3];

  assign coord[0] = data_i.in_x;
  assign coord[1] = data_i.in_y;
  assign coord[2] = data_i.in_z;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = $signed(row_i[r][16*c +: 16]) * coord[c];
      end
      // translation column: entry times one in q16.16
      if (data_i.operation != hpt_pkg::OP_VECTOR || r == 3) begin
        prod_d[r][3] = hpt_pkg::PROD_W'($signed({row_i[r][63:48], 16'h0000}));
      end else begin
        prod_d[r][3] = '0;
      end
    end
    for (int r = 0; r < 4; r++) begin
      acc_d[r] = hpt_pkg::ACC_W'(prod_q[r][0]) + hpt_pkg::ACC_W'(prod_q[r][1])
               + hpt_pkg::ACC_W'(prod_q[r][2]) + hpt_pkg::ACC_W'(prod_q[r][3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      op1_q  <= data_i.operation;
      acc_q  <= acc_d;
      op2_q  <= op1_q;
    end
  end

  assign acc_o = acc_q;
  assign op_o  = op2_q;

endmodule

// ----- design/hpt_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module hpt_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [hpt_pkg::MAG_W-1:0] num_i,
  input  logic [hpt_pkg::MAG_W-1:0] den_i,
  output logic [hpt_pkg::QB-1:0]    q_o,
  output logic                      rnd_o
);

  logic [hpt_pkg::RW-1:0]    r_q [hpt_pkg::QB];
  logic [hpt_pkg::QB-1:0]    q_q [hpt_pkg::QB];
  logic [hpt_pkg::MAG_W-1:0] d_q [hpt_pkg::QB];

  for (genvar s = 0; s < hpt_pkg::QB; s++) begin : g_stage
    localparam int unsigned K = hpt_pkg::QB - 1 - s;
    logic [hpt_pkg::RW-1:0]    r_in;
    logic [hpt_pkg::QB-1:0]    q_in;
    logic [hpt_pkg::MAG_W-1:0] d_in;
    logic [hpt_pkg::RW-1:0]    dsh;
    logic [hpt_pkg::RW-1:0]    r_d;
    logic [hpt_pkg::QB-1:0]    q_d;
    logic                      ge;

    if (s == 0) begin : g_first
      assign r_in = hpt_pkg::RW'({num_i, {hpt_pkg::FRAC_W{1'b0}}});
      assign q_in = '0;
      assign d_in = den_i;
    end else begin : g_next
      assign r_in = r_q[s-1];
      assign q_in = q_q[s-1];
      assign d_in = d_q[s-1];
    end

    always_comb begin
      dsh    = hpt_pkg::RW'(d_in) << K;
      ge     = r_in >= dsh;
      r_d    = ge ? r_in - dsh : r_in;
      q_d    = q_in;
      q_d[K] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s] <= r_d;
        q_q[s] <= q_d;
        d_q[s] <= d_in;
      end
    end
  end

  assign q_o   = q_q[hpt_pkg::QB-1];
  assign rnd_o = {r_q[hpt_pkg::QB-1][hpt_pkg::MAG_W-1:0], 1'b0} >= {1'b0, d_q[hpt_pkg::QB-1]};

endmodule

// ----- design/homogeneous_point_transform.sv -----
// top level of the homogeneous 4x4 point transform pipeline
//
// input channel: in_valid_i, in_stall_o, in_data_i (operation and x, y, z
// in q16.16); a transfer happens when valid is high and stall is low.
// output channel: out_valid_o, out_stall_i, out_data_o (x, y, z and the
// divide-by-zero flag), one result per accepted item, in order.
// matrix rows are written through cfg_we_i, cfg_idx_i, cfg_data_i; the user
// must do so only while idle; the block itself does not enforce this.
// all three modes use the same pipeline: two multiply/sum stages, one setup
// stage, 31 divider stages (one quotient bit per stage) and one output stage.
// the divider is fully pipelined; one item per cycle enters unless stalled.
// reset clears all valid bits and loads the identity matrix.
// when the receiver stalls a held result, the whole pipeline freezes and
// in_stall_o is raised; nothing is lost or repeated.
module homogeneous_point_transform (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  hpt_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output hpt_pkg::out_t             out_data_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [hpt_pkg::ROW_W-1:0] cfg_data_i
);

  localparam int unsigned DEPTH = hpt_pkg::QB + 4;

  logic [hpt_pkg::ROW_W-1:0]          row_q [4];
  logic                               en;
  logic [DEPTH-1:0]                   vld_q;
  logic [1:0]                         mac_op;
  logic signed [hpt_pkg::ACC_W-1:0]   acc [4];
  hpt_pkg::side_t                     side_d;
  hpt_pkg::side_t                     side_q [hpt_pkg::QB+1];
  logic [2:0][hpt_pkg::MAG_W-1:0]     num_d;
  logic [2:0][hpt_pkg::MAG_W-1:0]     num_q;
  logic [hpt_pkg::MAG_W-1:0]          den_d;
  logic [hpt_pkg::MAG_W-1:0]          den_q;
  logic [hpt_pkg::QB-1:0]             quo [3];
  logic [2:0]                         rnd;
  hpt_pkg::out_t                      out_d;
  hpt_pkg::out_t                      out_q;
  logic [2:0][hpt_pkg::COORD_W-1:0]   res;

  assign en         = !(vld_q[DEPTH-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= hpt_pkg::ROW0_RST;
      row_q[1] <= hpt_pkg::ROW1_RST;
      row_q[2] <= hpt_pkg::ROW2_RST;
      row_q[3] <= hpt_pkg::ROW3_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hpt_pkg::REG_ROW0: row_q[0] <= cfg_data_i;
        hpt_pkg::REG_ROW1: row_q[1] <= cfg_data_i;
        hpt_pkg::REG_ROW2: row_q[2] <= cfg_data_i;
        hpt_pkg::REG_ROW3: row_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  hpt_mac u_mac (
    .clk_i  (clk_i),
    .en_i   (en),
    .data_i (in_data_i),
    .row_i  (row_q),
    .op_o   (mac_op),
    .acc_o  (acc)
  );

  // setup: magnitudes, signs, range check and the no-divide results
  always_comb begin
    side_d.op = mac_op;
    side_d.wz = acc[3] == '0;
    den_d     = acc[3][hpt_pkg::ACC_W-1] ? hpt_pkg::MAG_W'(-acc[3])
                                         : hpt_pkg::MAG_W'(acc[3]);
    for (int i = 0; i < 3; i++) begin
      num_d[i]      = acc[i][hpt_pkg::ACC_W-1] ? hpt_pkg::MAG_W'(-acc[i])
                                               : hpt_pkg::MAG_W'(acc[i]);
      side_d.neg[i] = acc[i][hpt_pkg::ACC_W-1] != acc[3][hpt_pkg::ACC_W-1];
      side_d.ovf[i] = {{hpt_pkg::INT_LIM{1'b0}}, num_d[i]}
                      >= ({{hpt_pkg::INT_LIM{1'b0}}, den_d} << hpt_pkg::INT_LIM);
      side_d.aff[i] = hpt_pkg::to_q16(acc[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      num_q     <= num_d;
      den_q     <= den_d;
      for (int s = 1; s <= hpt_pkg::QB; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    hpt_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[i]),
      .den_i (den_q),
      .q_o   (quo[i]),
      .rnd_o (rnd[i])
    );
  end

  // round, sign and saturate the quotients, then pick the mode result
  always_comb begin
    logic [hpt_pkg::COORD_W-1:0] mag;
    hpt_pkg::side_t sd;
    sd  = side_q[hpt_pkg::QB];
    mag = '0;
    for (int i = 0; i < 3; i++) begin
      mag = {1'b0, quo[i]} + hpt_pkg::COORD_W'(rnd[i]);
      if (sd.ovf[i]) begin
        res[i] = sd.neg[i] ? hpt_pkg::Q_MIN : hpt_pkg::Q_MAX;
      end else if (sd.neg[i]) begin
        res[i] = -mag;
      end else if (mag[hpt_pkg::COORD_W-1]) begin
        res[i] = hpt_pkg::Q_MAX;
      end else begin
        res[i] = mag;
      end
    end
    if (sd.op == hpt_pkg::OP_POINT) begin
      out_d.divide_by_zero = sd.wz;
      out_d.out_x = sd.wz ? '0 : res[0];
      out_d.out_y = sd.wz ? '0 : res[1];
      out_d.out_z = sd.wz ? '0 : res[2];
    end else begin
      out_d.divide_by_zero = 1'b0;
      out_d.out_x = sd.aff[0];
      out_d.out_y = sd.aff[1];
      out_d.out_z = sd.aff[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[DEPTH-1];
  assign out_data_o  = out_q;

endmodule

// ----- dv/hpt_checker.sv -----
// checker of the homogeneous point transform: predicts each result and compares it
module hpt_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  hpt_pkg::in_t              in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  hpt_pkg::out_t             out_data_i,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [hpt_pkg::ROW_W-1:0] cfg_data_i,
  output int                        errors_o,
  output int                        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [hpt_pkg::ROW_W-1:0] matrix [4];
  hpt_pkg::out_t             expected_q [$];

  function automatic longint entry(logic [hpt_pkg::ROW_W-1:0] row, int col);
    logic signed [hpt_pkg::ENTRY_W-1:0] e;
    e = row[16*col +: 16];
    return longint'(e);
  endfunction

  function automatic longint dot_row(logic [hpt_pkg::ROW_W-1:0] row, longint x, longint y,
                                     longint z, bit translate);
    longint acc;
    acc = entry(row, 0) * x + entry(row, 1) * y + entry(row, 2) * z;
    if (translate) acc += entry(row, 3) * 65536;
    return acc;
  endfunction

  function automatic logic [31:0] clamp(longint v);
    if (v > 64'sd2147483647) return hpt_pkg::Q_MAX;
    if (v < -64'sd2147483648) return hpt_pkg::Q_MIN;
    return v[31:0];
  endfunction

  function automatic logic [31:0] round_q16(longint acc);
    return clamp((acc + 2048) >>> 12);
  endfunction

  function automatic logic [31:0] quotient_q16(longint n, longint d);
    bit      neg;
    longint  an, ad, q, r;
    neg = (n < 0) != (d < 0);
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q = an / ad;
    r = an % ad;
    if (q >= 32768) return neg ? hpt_pkg::Q_MIN : hpt_pkg::Q_MAX;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= ad) begin
        r -= ad;
        q |= 1;
      end
    end
    if ((r << 1) >= ad) q += 1;
    return clamp(neg ? -q : q);
  endfunction

  function automatic hpt_pkg::out_t transform(hpt_pkg::in_t item);
    hpt_pkg::out_t res;
    longint        x, y, z, ax, ay, az, aw;
    bit            translate;
    x = longint'(item.in_x);
    y = longint'(item.in_y);
    z = longint'(item.in_z);
    translate = (item.operation != hpt_pkg::OP_VECTOR);
    ax = dot_row(matrix[0], x, y, z, translate);
    ay = dot_row(matrix[1], x, y, z, translate);
    az = dot_row(matrix[2], x, y, z, translate);
    res = '0;
    if (item.operation == hpt_pkg::OP_POINT) begin
      aw = dot_row(matrix[3], x, y, z, 1'b1);
      if (aw == 0) begin
        res.divide_by_zero = 1'b1;
      end else begin
        res.out_x = quotient_q16(ax, aw);
        res.out_y = quotient_q16(ay, aw);
        res.out_z = quotient_q16(az, aw);
      end
    end else begin
      res.out_x = round_q16(ax);
      res.out_y = round_q16(ay);
      res.out_z = round_q16(az);
    end
    return res;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    hpt_pkg::out_t want;
    int            fails;
    fails = 0;
    if (!rst_ni) begin
      matrix[0] <= hpt_pkg::ROW0_RST;
      matrix[1] <= hpt_pkg::ROW1_RST;
      matrix[2] <= hpt_pkg::ROW2_RST;
      matrix[3] <= hpt_pkg::ROW3_RST;
      expected_q.delete();
      errors_o <= 0;
    end else begin
      if (cfg_we_i) matrix[cfg_idx_i] <= cfg_data_i;
      if (in_valid_i && !in_stall_i) expected_q.push_back(transform(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (want.out_x !== out_data_i.out_x) begin
            $error("out_x expected %0d got %0d", want.out_x, out_data_i.out_x);
            fails++;
          end
          if (want.out_y !== out_data_i.out_y) begin
            $error("out_y expected %0d got %0d", want.out_y, out_data_i.out_y);
            fails++;
          end
          if (want.out_z !== out_data_i.out_z) begin
            $error("out_z expected %0d got %0d", want.out_z, out_data_i.out_z);
            fails++;
          end
          if (want.divide_by_zero !== out_data_i.divide_by_zero) begin
            $error("divide_by_zero expected %0b got %0b", want.divide_by_zero,
                   out_data_i.divide_by_zero);
            fails++;
          end
        end
      end
      errors_o <= errors_o + fails;
    end
  end
endmodule

// ----- dv/tb.sv -----
// testbench top of the homogeneous point transform: stimulus, matrix settings and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 35;
  localparam int WATCHDOG = 20000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  hpt_pkg::in_t              in_data = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  hpt_pkg::out_t             out_data;
  logic                      cfg_we = 1'b0;
  logic [1:0]                cfg_idx = hpt_pkg::REG_ROW0;
  logic [hpt_pkg::ROW_W-1:0] cfg_data = '0;
  int                        errors;
  int                        pending;
  int                        send_idle_pct = 0;
  int                        recv_stall_pct = 0;
  bit                        hold_off = 1'b0;
  int                        quiet = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  homogeneous_point_transform dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  hpt_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  // receiver stalls, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("homogeneous_point_transform verification failed");
      $finish;
    end
  end

  task automatic send(hpt_pkg::in_t item);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // back-to-back version keeps valid high between transfers unless the item is last or an idle gap is drawn
  task automatic stream(hpt_pkg::in_t item, bit last);
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (last || $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_row(logic [1:0] idx, logic [hpt_pkg::ROW_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return {{14{1'($urandom_range(1))}}, 18'($urandom)};
      3: return 32'($signed(10'($urandom))) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed(6'($urandom))) <<< 10;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic hpt_pkg::in_t rand_item();
    hpt_pkg::in_t item;
    item.operation = 2'($urandom_range(3));
    item.in_x = rand_coord();
    item.in_y = rand_coord();
    item.in_z = rand_coord();
    return item;
  endfunction

  task automatic random_matrix(bit sparse);
    logic [hpt_pkg::ROW_W-1:0] row;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        row[16*c +: 16] = (sparse && $urandom_range(1)) ? 16'h0000 : rand_entry();
      end
      write_row(2'(r), row);
    end
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) stream(rand_item(), i == count - 1);
  endtask

  initial begin
    hpt_pkg::in_t item;
    logic [31:0] edges [4];
    edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'h0001_0000};
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // identity matrix: extremes, every operation incl. the undefined one
    for (int i = 0; i < 16; i++) begin
      item.operation = 2'(i % 4);
      item.in_x = edges[i % 4];
      item.in_y = edges[(i / 4) % 4];
      item.in_z = edges[(i + 1) % 4];
      send(item);
    end
    drain();

    // zero w row, then a tiny w to force divide saturation and ties
    write_row(hpt_pkg::REG_ROW3, 64'h0);
    for (int o = 0; o < 4; o++) begin
      item = '{2'(o), 32'h0001_8000, 32'hffff_0000, 32'h7fff_ffff};
      send(item);
    end
    drain();
    write_row(hpt_pkg::REG_ROW3, 64'h0001_0000_0000_0000);
    write_row(hpt_pkg::REG_ROW0, 64'h7fff_7fff_7fff_7fff);
    item = '{hpt_pkg::OP_POINT, 32'h0000_0003, 32'h0, 32'h0};
    send(item);
    item = '{hpt_pkg::OP_AFFINE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    send(item);
    drain();
    write_row(hpt_pkg::REG_ROW1, 64'h8000_8000_8000_8000);
    write_row(hpt_pkg::REG_ROW2, 64'hffff_ffff_ffff_ffff);
    for (int o = 0; o < 3; o++) begin
      item = '{2'(o), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      send(item);
    end
    drain();

    // random phases over varied matrices and idling mixes
    for (int p = 0; p < 8; p++) begin
      random_matrix(p[0]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      random_phase(160);
      drain();
    end

    // long receiver hold-off while items keep coming, then a full pause
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
      end
      random_phase(100);
    join
    while (pending != 0) @(negedge clk);
    random_phase(40);
    drain();

    if (errors == 0) begin
      $display("homogeneous_point_transform verification clean");
    end else begin
      $display("homogeneous_point_transform verification failed");
    end
    $finish;
  end
endmodule
